// ===== hdl/btat_pkg.sv =====
// Shared types and constants for the baseline threshold auto-tuner.
`timescale 1ns / 1ps

package btat_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W    = 24;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 16;
    localparam int MEAN_W      = 24;
    localparam int SCOUNT_W    = 24;
    localparam int MIN_SMP_W   = 24;
    localparam int MULT_W      = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 64;

    // Register reset values
    localparam logic [MIN_SMP_W-1:0] RST_MIN_SAMPLES   = 24'd60;
    localparam logic [TIME_W-1:0]    RST_UPD_INTERVAL  = 32'd60000;
    localparam logic [MULT_W-1:0]    RST_MARGIN_MULT   = 8'd32;
    localparam logic [THR_W-1:0]     RST_MARGIN_MIN    = 16'd15;
    localparam logic [THR_W-1:0]     RST_THR_FLOOR     = 16'd10;
    localparam logic [THR_W-1:0]     RST_THR_CEILING   = 16'd1000;
    localparam logic [THR_W-1:0]     RST_INIT_THR      = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_MIN_SAMPLES,
        REG_UPDATE_INTERVAL,
        REG_MARGIN_MULT,
        REG_MARGIN_MIN,
        REG_THR_FLOOR,
        REG_THR_CEILING,
        REG_INIT_THR
    } reg_idx_t;

    // Micro-operations the datapath understands
    typedef enum logic [3:0] {
        OP_WAIT_IN,
        OP_ACCUM,
        OP_CHECK,
        OP_DIV,
        OP_MEAN,
        OP_MUL,
        OP_PICK,
        OP_CLAMP,
        OP_EMIT
    } op_t;

    // Jump conditions; a true condition loads the target, else the step advances
    typedef enum logic [2:0] {
        JC_NONE,
        JC_NO_ACCEPT,
        JC_DIV_MORE,
        JC_NO_UPDATE,
        JC_OUT_BUSY
    } jcond_t;

    typedef logic [3:0] step_t;

    localparam step_t S_WAIT  = 4'd0;
    localparam step_t S_ACCUM = 4'd1;
    localparam step_t S_CHECK = 4'd2;
    localparam step_t S_DIV   = 4'd3;
    localparam step_t S_MEAN  = 4'd4;
    localparam step_t S_MUL   = 4'd5;
    localparam step_t S_PICK  = 4'd6;
    localparam step_t S_CLAMP = 4'd7;
    localparam step_t S_EMIT  = 4'd8;
    localparam step_t S_LAST  = S_EMIT;

    typedef struct packed {
        op_t    op;
        jcond_t cond;
        step_t  target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic div_more;
        logic do_update;
        logic out_busy;
    } status_t;

endpackage

// ===== hdl/btat_seq.sv =====
// Microprogram sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps

module btat_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  btat_pkg::status_t  status,
    output btat_pkg::ctrl_t    ctrl
);

    btat_pkg::step_t pc_reg;
    btat_pkg::step_t pc_next;
    logic            take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= btat_pkg::S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // control ROM
    always_comb
    begin
        case (pc_reg)
            btat_pkg::S_WAIT:
                ctrl = '{btat_pkg::OP_WAIT_IN, btat_pkg::JC_NO_ACCEPT, btat_pkg::S_WAIT};
            btat_pkg::S_ACCUM:
                ctrl = '{btat_pkg::OP_ACCUM, btat_pkg::JC_NONE, btat_pkg::S_WAIT};
            btat_pkg::S_CHECK:
                ctrl = '{btat_pkg::OP_CHECK, btat_pkg::JC_NONE, btat_pkg::S_WAIT};
            btat_pkg::S_DIV:
                ctrl = '{btat_pkg::OP_DIV, btat_pkg::JC_DIV_MORE, btat_pkg::S_DIV};
            btat_pkg::S_MEAN:
                ctrl = '{btat_pkg::OP_MEAN, btat_pkg::JC_NO_UPDATE, btat_pkg::S_EMIT};
            btat_pkg::S_MUL:
                ctrl = '{btat_pkg::OP_MUL, btat_pkg::JC_NONE, btat_pkg::S_WAIT};
            btat_pkg::S_PICK:
                ctrl = '{btat_pkg::OP_PICK, btat_pkg::JC_NONE, btat_pkg::S_WAIT};
            btat_pkg::S_CLAMP:
                ctrl = '{btat_pkg::OP_CLAMP, btat_pkg::JC_NONE, btat_pkg::S_WAIT};
            btat_pkg::S_EMIT:
                ctrl = '{btat_pkg::OP_EMIT, btat_pkg::JC_OUT_BUSY, btat_pkg::S_EMIT};
            default:
                ctrl = '{btat_pkg::OP_WAIT_IN, btat_pkg::JC_NO_ACCEPT, btat_pkg::S_WAIT};
        endcase
    end

    // next step
    always_comb
    begin
        case (ctrl.cond)
            btat_pkg::JC_NO_ACCEPT: take = !status.accept;
            btat_pkg::JC_DIV_MORE:  take = status.div_more;
            btat_pkg::JC_NO_UPDATE: take = !status.do_update;
            btat_pkg::JC_OUT_BUSY:  take = status.out_busy;
            default:                take = 1'b0;
        endcase

        if (take)
        begin
            pc_next = ctrl.target;
        end
        else if (pc_reg == btat_pkg::S_LAST)
        begin
            pc_next = btat_pkg::S_WAIT;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

endmodule

// ===== hdl/baseline_threshold_autotune.sv =====
// Top level of the baseline threshold auto-tuner: datapath, registers, stream ports.
`timescale 1ns / 1ps

// Learns a stillness threshold from the sensor baseline. Each request carries a
// sample (FRAC_BITS fraction bits), a door-closed flag and a ms timestamp;
// while the door is closed samples are summed and counted, an open door clears
// the collection. Once min_samples are in and update_interval ms have passed
// (or no update happened yet) the threshold becomes
// max(mean*margin_multiplier/16, mean+margin_minimum), clamped to floor and
// ceiling (the ceiling wins). Every request returns exactly one result.
// Steps: accept, accumulate, check, then the bit-serial restoring divider that
// forms the mean, one quotient bit per cycle, then mean; when the threshold is
// recomputed, multiply, pick and clamp follow, and emit holds while the output
// is busy. A finished result sits in the output register, so the next request
// is taken while it waits.
// Configuration writes must only be issued while no request is in flight.

module baseline_threshold_autotune #(
    parameter int FRAC_BITS  = 8,
    parameter int COUNT_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [btat_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // sample[23:0], now_ms[55:24]
    input  logic                             s_axis_tuser,  // door_closed
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [btat_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // threshold[15:0], mean[39:16],
                                                            // sample_count[63:40]
    output logic                             m_axis_tuser,  // threshold_changed
    // register writes
    input  logic                             cfg_wr_en,
    input  logic [btat_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btat_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // running sum needs sample width plus count width
    localparam int SUM_W   = btat_pkg::SAMPLE_W + COUNT_BITS;
    localparam int ITER_W  = $clog2(SUM_W + 1);
    localparam int CMP_W   = (COUNT_BITS > btat_pkg::MIN_SMP_W) ? COUNT_BITS
                                                                : btat_pkg::MIN_SMP_W;
    // candidates carry FRAC_BITS+4 fraction bits
    localparam int ADD_W   = ((btat_pkg::MEAN_W > btat_pkg::THR_W + FRAC_BITS)
                              ? btat_pkg::MEAN_W : (btat_pkg::THR_W + FRAC_BITS)) + 5;
    localparam int CAND_W  = (ADD_W > 32) ? ADD_W : 32;
    localparam int TW      = CAND_W - (FRAC_BITS + 4);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    btat_pkg::ctrl_t   ctrl;
    btat_pkg::status_t status;

    // configuration registers
    logic                             enable_reg;
    logic [btat_pkg::MIN_SMP_W-1:0]   min_samples_reg;
    logic [btat_pkg::TIME_W-1:0]      update_interval_reg;
    logic [btat_pkg::MULT_W-1:0]      margin_mult_reg;
    logic [btat_pkg::THR_W-1:0]       margin_min_reg;
    logic [btat_pkg::THR_W-1:0]       thr_floor_reg;
    logic [btat_pkg::THR_W-1:0]       thr_ceiling_reg;

    // tuner state
    logic [SUM_W-1:0]                 sum_reg;
    logic [COUNT_BITS-1:0]            count_reg;
    logic [btat_pkg::TIME_W-1:0]      last_upd_reg;
    logic [btat_pkg::THR_W-1:0]       thr_reg;

    // per-request control
    logic                             do_update_reg;
    logic                             changed_reg;
    logic [ITER_W-1:0]                iter_reg;
    logic                             out_valid_reg;

    // payload
    logic [btat_pkg::SAMPLE_W-1:0]    sample_reg;
    logic                             door_reg;
    logic [btat_pkg::TIME_W-1:0]      now_reg;
    logic [SUM_W-1:0]                 quo_reg;
    logic [COUNT_BITS-1:0]            rem_reg;
    logic [btat_pkg::MEAN_W-1:0]      mean_reg;
    logic [CAND_W-1:0]                by_mult_reg;
    logic [CAND_W-1:0]                by_add_reg;
    logic [TW-1:0]                    t_reg;
    logic [btat_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic                             out_user_reg;

    logic                             accept;
    logic                             out_busy;
    logic [COUNT_BITS:0]              rem_shift;
    logic [COUNT_BITS+1:0]            rem_diff;
    logic                             interval_ok;
    logic                             enough;
    logic [CMP_W-1:0]                 count_ext;
    logic [CAND_W-1:0]                best;
    logic [TW-1:0]                    t_floor;
    logic [TW-1:0]                    t_clamp;
    logic [btat_pkg::THR_W-1:0]       t_new;

    btat_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign s_axis_tready = (ctrl.op == btat_pkg::OP_WAIT_IN);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;

    assign status.accept    = accept;
    assign status.div_more  = (iter_reg != ITER_W'(1));
    assign status.do_update = do_update_reg;
    assign status.out_busy  = out_busy;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // one restoring division step: partial remainder against the count
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, count_reg};

    assign count_ext   = CMP_W'(count_reg);
    assign enough      = count_ext >= CMP_W'(min_samples_reg);
    // a recorded time of zero means never updated
    assign interval_ok = (last_upd_reg == '0) ||
                         ((now_reg - last_upd_reg) >= update_interval_reg);

    assign best    = (by_mult_reg > by_add_reg) ? by_mult_reg : by_add_reg;
    // floor first, then ceiling, so the ceiling wins on a crossed pair
    assign t_floor = (t_reg < TW'(thr_floor_reg)) ? TW'(thr_floor_reg) : t_reg;
    assign t_clamp = (t_floor > TW'(thr_ceiling_reg)) ? TW'(thr_ceiling_reg) : t_floor;
    assign t_new   = t_clamp[btat_pkg::THR_W-1:0];

    // control state, tuner state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg          <= 1'b1;
            min_samples_reg     <= btat_pkg::RST_MIN_SAMPLES;
            update_interval_reg <= btat_pkg::RST_UPD_INTERVAL;
            margin_mult_reg     <= btat_pkg::RST_MARGIN_MULT;
            margin_min_reg      <= btat_pkg::RST_MARGIN_MIN;
            thr_floor_reg       <= btat_pkg::RST_THR_FLOOR;
            thr_ceiling_reg     <= btat_pkg::RST_THR_CEILING;
            sum_reg             <= '0;
            count_reg           <= '0;
            last_upd_reg        <= '0;
            thr_reg             <= btat_pkg::RST_INIT_THR;
            do_update_reg       <= 1'b0;
            changed_reg         <= 1'b0;
            iter_reg            <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                btat_pkg::OP_ACCUM:
                begin
                    if (enable_reg)
                    begin
                        if (!door_reg)
                        begin
                            sum_reg      <= '0;
                            count_reg    <= '0;
                            last_upd_reg <= '0;
                        end
                        else if (count_reg != COUNT_MAX)
                        begin
                            // saturated count freezes accumulation
                            sum_reg   <= sum_reg + SUM_W'(sample_reg);
                            count_reg <= count_reg + COUNT_BITS'(1);
                        end
                    end
                end
                btat_pkg::OP_CHECK:
                begin
                    do_update_reg <= enable_reg && door_reg && enough && interval_ok &&
                                     (count_reg != '0);
                    changed_reg   <= 1'b0;
                    iter_reg      <= ITER_W'(SUM_W);
                end
                btat_pkg::OP_DIV:
                begin
                    iter_reg <= iter_reg - ITER_W'(1);
                end
                btat_pkg::OP_CLAMP:
                begin
                    if (t_new != thr_reg)
                    begin
                        thr_reg     <= t_new;
                        changed_reg <= 1'b1;
                    end
                    last_upd_reg <= now_reg;
                end
                default:
                begin
                end
            endcase

            if (ctrl.op == btat_pkg::OP_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // the user must issue writes only while idle; the block does not enforce it
            if (cfg_wr_en)
            begin
                case (btat_pkg::reg_idx_t'(cfg_index))
                    btat_pkg::REG_ENABLE:
                    begin
                        enable_reg <= cfg_wdata[0];
                        if (cfg_wdata[0])
                        begin
                            sum_reg      <= '0;
                            count_reg    <= '0;
                            last_upd_reg <= '0;
                        end
                    end
                    btat_pkg::REG_MIN_SAMPLES:
                        min_samples_reg <= cfg_wdata[btat_pkg::MIN_SMP_W-1:0];
                    btat_pkg::REG_UPDATE_INTERVAL:
                        update_interval_reg <= cfg_wdata[btat_pkg::TIME_W-1:0];
                    btat_pkg::REG_MARGIN_MULT:
                        margin_mult_reg <= cfg_wdata[btat_pkg::MULT_W-1:0];
                    btat_pkg::REG_MARGIN_MIN:
                        margin_min_reg <= cfg_wdata[btat_pkg::THR_W-1:0];
                    btat_pkg::REG_THR_FLOOR:
                        thr_floor_reg <= cfg_wdata[btat_pkg::THR_W-1:0];
                    btat_pkg::REG_THR_CEILING:
                        thr_ceiling_reg <= cfg_wdata[btat_pkg::THR_W-1:0];
                    btat_pkg::REG_INIT_THR:
                    begin
                        // only matters as the threshold it loads
                        thr_reg <= cfg_wdata[btat_pkg::THR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            btat_pkg::OP_WAIT_IN:
            begin
                if (accept)
                begin
                    sample_reg <= s_axis_tdata[btat_pkg::SAMPLE_W-1:0];
                    now_reg    <= s_axis_tdata[btat_pkg::IN_DATA_W-1:btat_pkg::SAMPLE_W];
                    door_reg   <= s_axis_tuser;
                end
            end
            btat_pkg::OP_CHECK:
            begin
                quo_reg <= sum_reg;
                rem_reg <= '0;
            end
            btat_pkg::OP_DIV:
            begin
                if (!rem_diff[COUNT_BITS+1])
                begin
                    rem_reg <= rem_diff[COUNT_BITS-1:0];
                    quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[COUNT_BITS-1:0];
                    quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                end
            end
            btat_pkg::OP_MEAN:
            begin
                mean_reg <= (count_reg == '0) ? '0 : quo_reg[btat_pkg::MEAN_W-1:0];
            end
            btat_pkg::OP_MUL:
            begin
                by_mult_reg <= CAND_W'(mean_reg * margin_mult_reg);
                by_add_reg  <= (CAND_W'(mean_reg) + (CAND_W'(margin_min_reg) << FRAC_BITS))
                               << 4;
            end
            btat_pkg::OP_PICK:
            begin
                t_reg <= TW'(best >> (FRAC_BITS + 4));
            end
            btat_pkg::OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_data_reg <= {count_ext[btat_pkg::SCOUNT_W-1:0], mean_reg, thr_reg};
                    out_user_reg <= changed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
